[design/sfsa_pkg.sv]
// Shared types, constants and register codes for the sensor frame scaler.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package sfsa_pkg;

  // Front end sampling setup
  localparam int SAMPLES_PER_SUM = 5;
  localparam int ADC_BITS        = 12;

  localparam int SUM_W   = 15;
  localparam int SUM_MAX = 2 ** SUM_W - 1;

  // sum / SAMPLES_PER_SUM as multiply by ceil(2^K / S), exact for SUM_W-bit sums
  localparam int AVG_K   = SUM_W + $clog2(SAMPLES_PER_SUM);
  localparam int AVG_M   = (2 ** AVG_K + SAMPLES_PER_SUM - 1) / SAMPLES_PER_SUM;
  localparam int AVG_M_W = $clog2(AVG_M + 1);
  localparam int AVG_P_W = SUM_W + AVG_M_W;
  localparam int AVG_W   = $clog2(SUM_MAX / SAMPLES_PER_SUM + 1);

  // Water pressure
  localparam int WATER_OFFSET   = 55;
  localparam int WAVG_W         = $clog2(SUM_MAX / SAMPLES_PER_SUM + WATER_OFFSET + 1);
  localparam int K_WATER_GAIN   = 27499;
  localparam int WGAIN_W        = $clog2(K_WATER_GAIN + 1);
  localparam int K_WATER_BIAS   = 16384000;
  // bias with the +55 offset folded in, product taken on the bare average
  localparam int K_WATER_BIAS_A = K_WATER_BIAS - K_WATER_GAIN * WATER_OFFSET;
  localparam int WPROD_W        = AVG_W + WGAIN_W;
  localparam int KQ_W           = WPROD_W - 16;
  localparam int KPA_W          = 11;
  localparam int KPA_MAX        = 2 ** KPA_W - 1;
  localparam int THR_W          = 13;
  localparam int CMP_W          = 16;

  // Oil sensor voltage, Q16: floor(sum * VQ_NUM / VQ_DEN) + offset
  localparam int VQ_NUM   = 33 * 2 ** (16 - ADC_BITS);
  localparam int VQ_NUM_W = $clog2(VQ_NUM + 1);
  localparam int VQ_DEN   = 10 * SAMPLES_PER_SUM;
  localparam int VQ_X_W   = $clog2(SUM_MAX * VQ_NUM + 1);
  localparam int VQ_K     = VQ_X_W + $clog2(VQ_DEN);
  localparam longint VQ_M = ((longint'(1) << VQ_K) + VQ_DEN - 1) / VQ_DEN;
  localparam int VQ_M_W   = $clog2(VQ_M + 1);
  localparam int VQ_P_W   = VQ_X_W + VQ_M_W;
  localparam int K_V_OFFSET = 2621;
  localparam int VQ_W     = $clog2(SUM_MAX * VQ_NUM / VQ_DEN + K_V_OFFSET + 1);
  localparam int K_V_OPEN = 154009;
  localparam int K_V_REF  = 164823;
  localparam int K_R_SCALE = 1000;

  // Resistance divider: 1000*Vq / (K_V_REF - Vq) for Vq up to K_V_OPEN
  localparam int DIV_N_W = 28;
  localparam int DIV_D_W = 18;
  localparam int DIV_Q_W = 14;

  // Temperature segments
  localparam int R_SEG1   = 385;
  localparam int R_SEG2   = 691;
  localparam int R_SEG3   = 1340;
  localparam int T_OFF1   = 9751756;
  localparam int T_SLOPE1 = 8323;
  localparam int T_OFF2   = 8185446;
  localparam int T_SLOPE2 = 4259;
  localparam int T_OFF3   = 6651904;
  localparam int T_SLOPE3 = 2031;
  localparam int T_OFF4   = 5065932;
  localparam int T_SLOPE4 = 851;
  localparam int TOFF_W   = 24;
  localparam int TSLOPE_W = 14;
  localparam int TPROD_W  = TSLOPE_W + DIV_Q_W;
  localparam int TQ_W     = TPROD_W - 16;
  localparam int CELSIUS_W   = 8;
  localparam int CELSIUS_MAX = 2 ** CELSIUS_W - 1;

  // Scaled channels
  localparam int CHAN_N      = 3;
  localparam int K_CHAN_GAIN = 10551;
  localparam int CGAIN_W     = $clog2(K_CHAN_GAIN + 1);
  localparam int CPROD_W     = AVG_W + CGAIN_W;
  localparam int CQ_W        = CPROD_W - 16;
  localparam int CHAN_W      = 10;
  localparam int CHAN_MAX    = 2 ** CHAN_W - 1;

  // Configuration port
  localparam int LIM_W       = 8;
  localparam int CFG_DATA_W  = 13;
  localparam int CFG_INDEX_W = 3;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_OIL_TEMP_LIMIT   = 3'd0,
    REG_WATER_ZERO_FLOOR = 3'd1,
    REG_BREAK_THRESHOLD  = 3'd2,
    REG_SHORT_THRESHOLD  = 3'd3,
    REG_BAND_LOW_KPA     = 3'd4,
    REG_BAND_HIGH_KPA    = 3'd5,
    REG_IDLE_LIMIT_KPA   = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic [LIM_W-1:0] oil_temp_limit;
    logic [THR_W-1:0] water_zero_floor;
    logic [THR_W-1:0] break_threshold;
    logic [THR_W-1:0] short_threshold;
    logic [KPA_W-1:0] band_low_kpa;
    logic [KPA_W-1:0] band_high_kpa;
    logic [KPA_W-1:0] idle_limit_kpa;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    oil_temp_limit:   8'd80,
    water_zero_floor: 13'd640,
    break_threshold:  13'd300,
    short_threshold:  13'd3050,
    band_low_kpa:     11'd50,
    band_high_kpa:    11'd300,
    idle_limit_kpa:   11'd30
  };

  // Results that ride alongside the divider
  typedef struct packed {
    logic [CHAN_W-1:0] head_value;
    logic [CHAN_W-1:0] travel_value;
    logic [CHAN_W-1:0] handle_value;
    logic              oil_open;
    logic              water_alarm;
    logic              water_shorted;
    logic              water_broken;
    logic [KPA_W-1:0]  water_kpa;
  } side_t;

  // Result item, last field in the low bits
  typedef struct packed {
    logic [CHAN_W-1:0]    head_value;
    logic [CHAN_W-1:0]    travel_value;
    logic [CHAN_W-1:0]    handle_value;
    logic                 oil_alarm;
    logic [CELSIUS_W-1:0] oil_celsius;
    logic                 water_alarm;
    logic                 water_shorted;
    logic                 water_broken;
    logic [KPA_W-1:0]     water_kpa;
  } result_t;

  localparam int IN_W        = 5 * SUM_W;
  localparam int TDATA_IN_W  = ((IN_W + 7) / 8) * 8;
  localparam int OUT_W       = $bits(result_t);
  localparam int TDATA_OUT_W = ((OUT_W + 7) / 8) * 8;

endpackage

[design/sfsa_front.sv]
// Front pipeline: averages, water pressure and alarms, channel scaling,
// oil voltage and divider operands. Four stages. Depends on sfsa_pkg.
`timescale 1ns / 1ps

module sfsa_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [sfsa_pkg::SUM_W-1:0]     water_sum,
  input  logic [sfsa_pkg::SUM_W-1:0]     oil_sum,
  input  logic [sfsa_pkg::SUM_W-1:0]     handle_sum,
  input  logic [sfsa_pkg::SUM_W-1:0]     travel_sum,
  input  logic [sfsa_pkg::SUM_W-1:0]     head_sum,
  input  sfsa_pkg::cfg_t                 cfg,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [sfsa_pkg::DIV_N_W-1:0]   div_num,
  output logic [sfsa_pkg::DIV_D_W-1:0]   div_den,
  output sfsa_pkg::side_t                side
);

  localparam int NS = 4;

  logic [NS-1:0] v;
  logic [NS-1:0] go;

  // a stage moves when the output drains or some stage at or after it is empty
  always_comb begin
    for (int k = 0; k < NS; k++) begin
      go[k] = out_ready || ((v | NS'((1 << k) - 1)) != '1);
    end
  end

  assign in_ready  = go[0];
  assign out_valid = v[NS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (go[0]) v[0] <= in_valid;
      for (int k = 1; k < NS; k++) begin
        if (go[k]) v[k] <= v[k-1];
      end
    end
  end

  logic [sfsa_pkg::AVG_M_W-1:0]    avg_m;
  logic [sfsa_pkg::VQ_NUM_W-1:0]   vq_num;
  logic [sfsa_pkg::VQ_M_W-1:0]     vq_m;
  logic [sfsa_pkg::WGAIN_W-1:0]    wgain;
  logic [sfsa_pkg::CGAIN_W-1:0]    cgain;
  logic [sfsa_pkg::SUM_W-1:0]      csum [sfsa_pkg::CHAN_N];

  assign avg_m   = sfsa_pkg::AVG_M_W'(sfsa_pkg::AVG_M);
  assign vq_num  = sfsa_pkg::VQ_NUM_W'(sfsa_pkg::VQ_NUM);
  assign vq_m    = sfsa_pkg::VQ_M_W'(sfsa_pkg::VQ_M);
  assign wgain   = sfsa_pkg::WGAIN_W'(sfsa_pkg::K_WATER_GAIN);
  assign cgain   = sfsa_pkg::CGAIN_W'(sfsa_pkg::K_CHAN_GAIN);
  assign csum[0] = handle_sum;
  assign csum[1] = travel_sum;
  assign csum[2] = head_sum;

  // Stage 1: reciprocal multiplies for the averages, oil sum times VQ_NUM
  logic [sfsa_pkg::AVG_P_W-1:0] s1_wprod;
  logic [sfsa_pkg::AVG_P_W-1:0] s1_cprod [sfsa_pkg::CHAN_N];
  logic [sfsa_pkg::VQ_X_W-1:0]  s1_ox;

  always_ff @(posedge clk) begin
    if (go[0]) begin
      s1_wprod <= sfsa_pkg::AVG_P_W'(water_sum) * sfsa_pkg::AVG_P_W'(avg_m);
      for (int i = 0; i < sfsa_pkg::CHAN_N; i++) begin
        s1_cprod[i] <= sfsa_pkg::AVG_P_W'(csum[i]) * sfsa_pkg::AVG_P_W'(avg_m);
      end
      s1_ox <= sfsa_pkg::VQ_X_W'(oil_sum) * sfsa_pkg::VQ_X_W'(vq_num);
    end
  end

  // Stage 2: averages, threshold compares, gain multiplies, oil reciprocal multiply
  logic [sfsa_pkg::AVG_W-1:0]   wavg_bare;
  logic [sfsa_pkg::WAVG_W-1:0]  wavg;
  logic [sfsa_pkg::AVG_W-1:0]   cavg [sfsa_pkg::CHAN_N];

  logic [sfsa_pkg::WPROD_W-1:0] s2_wprod;
  logic                         s2_above;
  logic                         s2_broken;
  logic                         s2_shorted;
  logic [sfsa_pkg::CPROD_W-1:0] s2_cprod [sfsa_pkg::CHAN_N];
  logic [sfsa_pkg::VQ_P_W-1:0]  s2_vprod;

  always_comb begin
    wavg_bare = sfsa_pkg::AVG_W'(s1_wprod >> sfsa_pkg::AVG_K);
    wavg      = sfsa_pkg::WAVG_W'(wavg_bare) + sfsa_pkg::WAVG_W'(sfsa_pkg::WATER_OFFSET);
    for (int i = 0; i < sfsa_pkg::CHAN_N; i++) begin
      cavg[i] = sfsa_pkg::AVG_W'(s1_cprod[i] >> sfsa_pkg::AVG_K);
    end
  end

  always_ff @(posedge clk) begin
    if (go[1]) begin
      s2_wprod   <= sfsa_pkg::WPROD_W'(wavg_bare) * sfsa_pkg::WPROD_W'(wgain);
      s2_above   <= sfsa_pkg::CMP_W'(wavg) > sfsa_pkg::CMP_W'(cfg.water_zero_floor);
      s2_broken  <= sfsa_pkg::CMP_W'(wavg) < sfsa_pkg::CMP_W'(cfg.break_threshold);
      s2_shorted <= sfsa_pkg::CMP_W'(wavg) > sfsa_pkg::CMP_W'(cfg.short_threshold);
      for (int i = 0; i < sfsa_pkg::CHAN_N; i++) begin
        s2_cprod[i] <= sfsa_pkg::CPROD_W'(cavg[i]) * sfsa_pkg::CPROD_W'(cgain);
      end
      s2_vprod <= sfsa_pkg::VQ_P_W'(s1_ox) * sfsa_pkg::VQ_P_W'(vq_m);
    end
  end

  // Stage 3: pressure, channel values, oil voltage
  logic [sfsa_pkg::WPROD_W-1:0] wdiff;
  logic [sfsa_pkg::KQ_W-1:0]    kq;
  logic [sfsa_pkg::KPA_W-1:0]   kpa;
  logic [sfsa_pkg::CQ_W-1:0]    cq [sfsa_pkg::CHAN_N];
  logic [sfsa_pkg::CHAN_W-1:0]  cval [sfsa_pkg::CHAN_N];

  logic [sfsa_pkg::KPA_W-1:0]   s3_kpa;
  logic                         s3_broken;
  logic                         s3_shorted;
  logic [sfsa_pkg::CHAN_W-1:0]  s3_cval [sfsa_pkg::CHAN_N];
  logic [sfsa_pkg::VQ_W-1:0]    s3_vq;

  always_comb begin
    wdiff = s2_wprod - sfsa_pkg::WPROD_W'(sfsa_pkg::K_WATER_BIAS_A);
    kq    = sfsa_pkg::KQ_W'(wdiff >> 16);
    if (!s2_above || s2_wprod <= sfsa_pkg::WPROD_W'(sfsa_pkg::K_WATER_BIAS_A)) begin
      kpa = '0;
    end else if (kq > sfsa_pkg::KQ_W'(sfsa_pkg::KPA_MAX)) begin
      kpa = sfsa_pkg::KPA_W'(sfsa_pkg::KPA_MAX);
    end else begin
      kpa = sfsa_pkg::KPA_W'(kq);
    end
    for (int i = 0; i < sfsa_pkg::CHAN_N; i++) begin
      cq[i]   = sfsa_pkg::CQ_W'(s2_cprod[i] >> 16);
      cval[i] = (cq[i] > sfsa_pkg::CQ_W'(sfsa_pkg::CHAN_MAX)) ?
                sfsa_pkg::CHAN_W'(sfsa_pkg::CHAN_MAX) : sfsa_pkg::CHAN_W'(cq[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (go[2]) begin
      s3_kpa     <= kpa;
      s3_broken  <= s2_broken;
      s3_shorted <= s2_shorted;
      for (int i = 0; i < sfsa_pkg::CHAN_N; i++) begin
        s3_cval[i] <= cval[i];
      end
      s3_vq <= sfsa_pkg::VQ_W'(s2_vprod >> sfsa_pkg::VQ_K) +
               sfsa_pkg::VQ_W'(sfsa_pkg::K_V_OFFSET);
    end
  end

  // Stage 4: water alarm, open-sensor check, divider operands
  logic in_band;
  logic idle;

  assign in_band = (s3_kpa < cfg.band_high_kpa) && (s3_kpa > cfg.band_low_kpa);
  assign idle    = s3_kpa < cfg.idle_limit_kpa;

  always_ff @(posedge clk) begin
    if (go[3]) begin
      side.water_kpa     <= s3_kpa;
      side.water_broken  <= s3_broken;
      side.water_shorted <= s3_shorted;
      side.water_alarm   <= !(in_band || idle);
      // full voltage width, the open threshold does not fit 16 bits
      side.oil_open      <= s3_vq > sfsa_pkg::VQ_W'(sfsa_pkg::K_V_OPEN);
      side.handle_value  <= s3_cval[0];
      side.travel_value  <= s3_cval[1];
      side.head_value    <= s3_cval[2];
      // operands only meaningful when the sensor is not open
      div_num <= sfsa_pkg::DIV_N_W'(s3_vq) * sfsa_pkg::DIV_N_W'(sfsa_pkg::K_R_SCALE);
      div_den <= sfsa_pkg::DIV_D_W'(sfsa_pkg::K_V_REF) - sfsa_pkg::DIV_D_W'(s3_vq);
    end
  end

endmodule

[design/sfsa_div.sv]
// Pipelined restoring divider for the sensor resistance, one quotient bit
// per stage, side results carried along. Depends on sfsa_pkg.
`timescale 1ns / 1ps

module sfsa_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [sfsa_pkg::DIV_N_W-1:0]  num,
  input  logic [sfsa_pkg::DIV_D_W-1:0]  den,
  input  sfsa_pkg::side_t               side_in,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [sfsa_pkg::DIV_Q_W-1:0]  quo,
  output sfsa_pkg::side_t               side_out
);

  localparam int NS = sfsa_pkg::DIV_Q_W;
  localparam int DW = sfsa_pkg::DIV_D_W;
  localparam int QW = sfsa_pkg::DIV_Q_W;

  logic [NS-1:0] v;
  logic [NS-1:0] go;

  always_comb begin
    for (int k = 0; k < NS; k++) begin
      go[k] = out_ready || ((v | NS'((1 << k) - 1)) != '1);
    end
  end

  assign in_ready  = go[0];
  assign out_valid = v[NS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (go[0]) v[0] <= in_valid;
      for (int k = 1; k < NS; k++) begin
        if (go[k]) v[k] <= v[k-1];
      end
    end
  end

  // rem: partial remainder; lq: unused dividend bits above, quotient bits below
  logic [DW-1:0]   rem  [NS];
  logic [DW-1:0]   dd   [NS];
  logic [QW-1:0]   lq   [NS];
  sfsa_pkg::side_t sd   [NS];

  logic [DW-1:0]   rem_src [NS];
  logic [DW-1:0]   dd_src  [NS];
  logic [QW-1:0]   lq_src  [NS];
  logic [DW:0]     trial   [NS];
  logic            qbit    [NS];
  logic [DW-1:0]   rem_nxt [NS];

  always_comb begin
    // the quotient fits QW bits, so the top dividend bits start below den
    rem_src[0] = DW'(num >> QW);
    dd_src[0]  = den;
    lq_src[0]  = QW'(num);
    for (int k = 1; k < NS; k++) begin
      rem_src[k] = rem[k-1];
      dd_src[k]  = dd[k-1];
      lq_src[k]  = lq[k-1];
    end
    for (int k = 0; k < NS; k++) begin
      trial[k] = {rem_src[k], lq_src[k][QW-1]};
      qbit[k]  = trial[k] >= {1'b0, dd_src[k]};
      rem_nxt[k] = qbit[k] ? DW'(trial[k] - {1'b0, dd_src[k]}) : DW'(trial[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (go[0]) sd[0] <= side_in;
    for (int k = 1; k < NS; k++) begin
      if (go[k]) sd[k] <= sd[k-1];
    end
    for (int k = 0; k < NS; k++) begin
      if (go[k]) begin
        rem[k] <= rem_nxt[k];
        dd[k]  <= dd_src[k];
        lq[k]  <= {lq_src[k][QW-2:0], qbit[k]};
      end
    end
  end

  assign quo      = lq[NS-1];
  assign side_out = sd[NS-1];

endmodule

[design/sfsa_temp.sv]
// Oil temperature from sensor resistance: segment select and multiply,
// then subtract, clamp and alarm into the output register. Depends on sfsa_pkg.
`timescale 1ns / 1ps

module sfsa_temp (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [sfsa_pkg::DIV_Q_W-1:0]  r,
  input  sfsa_pkg::side_t               side,
  input  logic [sfsa_pkg::LIM_W-1:0]    oil_temp_limit,
  output logic                          out_valid,
  input  logic                          out_ready,
  output sfsa_pkg::result_t             res
);

  localparam int NS = 2;

  logic [NS-1:0] v;
  logic [NS-1:0] go;

  always_comb begin
    for (int k = 0; k < NS; k++) begin
      go[k] = out_ready || ((v | NS'((1 << k) - 1)) != '1);
    end
  end

  assign in_ready  = go[0];
  assign out_valid = v[NS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (go[0]) v[0] <= in_valid;
      if (go[1]) v[1] <= v[0];
    end
  end

  // Stage A: pick the segment and form slope * R
  logic [sfsa_pkg::TOFF_W-1:0]   off;
  logic [sfsa_pkg::TSLOPE_W-1:0] slope;

  always_comb begin
    if (r < sfsa_pkg::DIV_Q_W'(sfsa_pkg::R_SEG1)) begin
      off   = sfsa_pkg::TOFF_W'(sfsa_pkg::T_OFF1);
      slope = sfsa_pkg::TSLOPE_W'(sfsa_pkg::T_SLOPE1);
    end else if (r < sfsa_pkg::DIV_Q_W'(sfsa_pkg::R_SEG2)) begin
      off   = sfsa_pkg::TOFF_W'(sfsa_pkg::T_OFF2);
      slope = sfsa_pkg::TSLOPE_W'(sfsa_pkg::T_SLOPE2);
    end else if (r < sfsa_pkg::DIV_Q_W'(sfsa_pkg::R_SEG3)) begin
      off   = sfsa_pkg::TOFF_W'(sfsa_pkg::T_OFF3);
      slope = sfsa_pkg::TSLOPE_W'(sfsa_pkg::T_SLOPE3);
    end else begin
      off   = sfsa_pkg::TOFF_W'(sfsa_pkg::T_OFF4);
      slope = sfsa_pkg::TSLOPE_W'(sfsa_pkg::T_SLOPE4);
    end
  end

  logic [sfsa_pkg::TOFF_W-1:0]  sa_off;
  logic [sfsa_pkg::TPROD_W-1:0] sa_prod;
  sfsa_pkg::side_t              sa_side;

  always_ff @(posedge clk) begin
    if (go[0]) begin
      sa_off  <= off;
      sa_prod <= sfsa_pkg::TPROD_W'(slope) * sfsa_pkg::TPROD_W'(r);
      sa_side <= side;
    end
  end

  // Stage B: offset - product, zero when not positive or the sensor is open, saturate at 255
  logic signed [sfsa_pkg::TPROD_W:0] diff;
  logic [sfsa_pkg::TQ_W-1:0]         tq;
  logic [sfsa_pkg::CELSIUS_W-1:0]    celsius;

  always_comb begin
    diff = $signed({1'b0, sfsa_pkg::TPROD_W'(sa_off)}) - $signed({1'b0, sa_prod});
    tq   = sfsa_pkg::TQ_W'(diff >>> 16);
    if (sa_side.oil_open || diff <= 0) begin
      celsius = '0;
    end else if (tq > sfsa_pkg::TQ_W'(sfsa_pkg::CELSIUS_MAX)) begin
      celsius = sfsa_pkg::CELSIUS_W'(sfsa_pkg::CELSIUS_MAX);
    end else begin
      celsius = sfsa_pkg::CELSIUS_W'(tq);
    end
  end

  always_ff @(posedge clk) begin
    if (go[1]) begin
      res.water_kpa     <= sa_side.water_kpa;
      res.water_broken  <= sa_side.water_broken;
      res.water_shorted <= sa_side.water_shorted;
      res.water_alarm   <= sa_side.water_alarm;
      res.oil_celsius   <= celsius;
      res.oil_alarm     <= celsius > oil_temp_limit;
      res.handle_value  <= sa_side.handle_value;
      res.travel_value  <= sa_side.travel_value;
      res.head_value    <= sa_side.head_value;
    end
  end

endmodule

[design/sensor_frame_scaler_alarm.sv]
// Sensor frame scaler: an accepted item passes 4 front stages, 14 resistance
// divider stages and 2 temperature stages. Throughput one item per cycle while
// the output is taken; each stage advances on its own, so bubbles close up
// while the output waits. Reset clears all valid bits and loads the
// register defaults; payload registers are not reset.
// Depends on sfsa_pkg, sfsa_front, sfsa_div, sfsa_temp.
`timescale 1ns / 1ps

module sensor_frame_scaler_alarm (
  input  logic                                clk,
  input  logic                                rst,
  // fields from bit 0: water_sum, oil_sum, handle_sum, travel_sum, head_sum
  input  logic [sfsa_pkg::TDATA_IN_W-1:0]     s_tdata,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // fields from bit 0: water_kpa, water_broken, water_shorted, water_alarm,
  // oil_celsius, oil_alarm, handle_value, travel_value, head_value
  output logic [sfsa_pkg::TDATA_OUT_W-1:0]    m_tdata,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  input  logic                                cfg_wen,
  input  logic [sfsa_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [sfsa_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  sfsa_pkg::cfg_t cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= sfsa_pkg::CFG_RESET;
    end else if (cfg_wen) begin
      case (cfg_index)
        sfsa_pkg::REG_OIL_TEMP_LIMIT:   cfg.oil_temp_limit   <= sfsa_pkg::LIM_W'(cfg_wdata);
        sfsa_pkg::REG_WATER_ZERO_FLOOR: cfg.water_zero_floor <= sfsa_pkg::THR_W'(cfg_wdata);
        sfsa_pkg::REG_BREAK_THRESHOLD:  cfg.break_threshold  <= sfsa_pkg::THR_W'(cfg_wdata);
        sfsa_pkg::REG_SHORT_THRESHOLD:  cfg.short_threshold  <= sfsa_pkg::THR_W'(cfg_wdata);
        sfsa_pkg::REG_BAND_LOW_KPA:     cfg.band_low_kpa     <= sfsa_pkg::KPA_W'(cfg_wdata);
        sfsa_pkg::REG_BAND_HIGH_KPA:    cfg.band_high_kpa    <= sfsa_pkg::KPA_W'(cfg_wdata);
        sfsa_pkg::REG_IDLE_LIMIT_KPA:   cfg.idle_limit_kpa   <= sfsa_pkg::KPA_W'(cfg_wdata);
        default: ;
      endcase
    end
  end

  localparam int SW = sfsa_pkg::SUM_W;

  logic                           fr_valid;
  logic                           fr_ready;
  logic [sfsa_pkg::DIV_N_W-1:0]   fr_num;
  logic [sfsa_pkg::DIV_D_W-1:0]   fr_den;
  sfsa_pkg::side_t                fr_side;

  logic                           dv_valid;
  logic                           dv_ready;
  logic [sfsa_pkg::DIV_Q_W-1:0]   dv_quo;
  sfsa_pkg::side_t                dv_side;

  sfsa_pkg::result_t              res;

  sfsa_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .water_sum  (s_tdata[0*SW +: SW]),
    .oil_sum    (s_tdata[1*SW +: SW]),
    .handle_sum (s_tdata[2*SW +: SW]),
    .travel_sum (s_tdata[3*SW +: SW]),
    .head_sum   (s_tdata[4*SW +: SW]),
    .cfg        (cfg),
    .out_valid  (fr_valid),
    .out_ready  (fr_ready),
    .div_num    (fr_num),
    .div_den    (fr_den),
    .side       (fr_side)
  );

  sfsa_div u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fr_valid),
    .in_ready  (fr_ready),
    .num       (fr_num),
    .den       (fr_den),
    .side_in   (fr_side),
    .out_valid (dv_valid),
    .out_ready (dv_ready),
    .quo       (dv_quo),
    .side_out  (dv_side)
  );

  sfsa_temp u_temp (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (dv_valid),
    .in_ready       (dv_ready),
    .r              (dv_quo),
    .side           (dv_side),
    .oil_temp_limit (cfg.oil_temp_limit),
    .out_valid      (m_tvalid),
    .out_ready      (m_tready),
    .res            (res)
  );

  assign m_tdata = sfsa_pkg::TDATA_OUT_W'(res);

  // the input only stalls when every stage is full and the output is held
  a_stall_source: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (m_tvalid && !m_tready))
    else $error("input stalled with room in the pipeline");

  // resistance is at least 16 ohm for any valid voltage, so the first
  // segment tops out just below this
  a_celsius_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (res.oil_celsius <= 8'd150))
    else $error("oil temperature out of reachable range");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid right after reset");

endmodule

[dv/testbench.sv]
`timescale 1ns / 1ps
// Self-checking bench for sensor_frame_scaler_alarm: streams corner and random
// sensor frames under several register settings and checks every result.
// Depends on sfsa_pkg and the design sources.

module testbench;
  import sfsa_pkg::*;

  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 3'd7;
  localparam int SUM_TOP     = 2 ** SUM_W - 1;
  localparam int SUM_RANGE   = 20475;
  localparam int LONG_HOLD   = 400;
  localparam int MAX_REPORTS = 10;
  localparam int DRAIN_WAIT  = 40;

  // input item, water_sum in the low bits
  typedef struct packed {
    logic [SUM_W-1:0] head_sum;
    logic [SUM_W-1:0] travel_sum;
    logic [SUM_W-1:0] handle_sum;
    logic [SUM_W-1:0] oil_sum;
    logic [SUM_W-1:0] water_sum;
  } frame_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic [TDATA_IN_W-1:0]  s_tdata = '0;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [TDATA_OUT_W-1:0] m_tdata;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic                   cfg_wen = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

  frame_t  frame_q[$];
  result_t scaled_q[$];
  cfg_t    cfg_shadow;
  frame_t  cur_frame;
  int      src_gap = 0;
  int      sink_gap = 0;
  int      hold_left = 0;
  int      mismatches = 0;
  bit      idle_on = 1'b1;
  bit      stall_arm = 1'b0;
  bit      stall_done = 1'b0;

  sensor_frame_scaler_alarm dut (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cfg_wen  (cfg_wen),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------- scaling predictor ----------------

  function automatic longint q16_line(longint offset, longint slope, longint x);
    longint v;
    v = offset - slope * x;
    return (v <= 0) ? 64'sd0 : (v >>> 16);
  endfunction

  function automatic logic [CHAN_W-1:0] chan_scale(logic [SUM_W-1:0] sum);
    longint v;
    v = (longint'(10551) * (longint'(sum) / 5)) >>> 16;  // 0.161 * avg
    return (v > 1023) ? 10'd1023 : v[CHAN_W-1:0];
  endfunction

  function automatic result_t scale_frame(frame_t f, cfg_t c);
    result_t r;
    longint  avg, kpa, vq, ohm, deg;
    avg = longint'(f.water_sum) / 5 + 55;
    kpa = 0;
    if (avg > longint'(c.water_zero_floor)) begin
      kpa = q16_line(-16384000, -27499, avg);  // 0.4196 * avg - 250
      if (kpa > 2047)
        kpa = 2047;
    end
    r.water_kpa     = kpa[KPA_W-1:0];
    r.water_broken  = avg < longint'(c.break_threshold);
    r.water_shorted = avg > longint'(c.short_threshold);
    // clear inside the band or with the pump idle
    r.water_alarm = !((kpa > longint'(c.band_low_kpa) && kpa < longint'(c.band_high_kpa)) ||
                      kpa < longint'(c.idle_limit_kpa));

    vq = longint'(f.oil_sum) * 33 * 65536 / (10 * 5 * 4096) + 2621;
    if (vq > 154009) begin
      deg = 0;  // open sensor, above 2.35 V
    end else begin
      ohm = 1000 * vq / (164823 - vq);
      if (ohm < 385)
        deg = q16_line(9751756, 8323, ohm);
      else if (ohm < 691)
        deg = q16_line(8185446, 4259, ohm);
      else if (ohm < 1340)
        deg = q16_line(6651904, 2031, ohm);
      else
        deg = q16_line(5065932, 851, ohm);
      if (deg > 255)
        deg = 255;
    end
    r.oil_celsius  = deg[CELSIUS_W-1:0];
    r.oil_alarm    = deg > longint'(c.oil_temp_limit);
    r.handle_value = chan_scale(f.handle_sum);
    r.travel_value = chan_scale(f.travel_sum);
    r.head_value   = chan_scale(f.head_sum);
    return r;
  endfunction

  // ---------------- stimulus helpers ----------------

  function automatic logic [SUM_W-1:0] clip_sum(int v);
    if (v < 0)
      return '0;
    if (v > SUM_TOP)
      return SUM_TOP[SUM_W-1:0];
    return v[SUM_W-1:0];
  endfunction

  function automatic logic [SUM_W-1:0] rand_sum();
    int unsigned v;
    case ($urandom_range(0, 9))
      0:       v = 0;
      1:       v = SUM_TOP;
      2:       v = $urandom_range(SUM_RANGE - 80, SUM_RANGE);
      3, 4:    v = $urandom_range(0, SUM_TOP);
      default: v = $urandom_range(0, SUM_RANGE);
    endcase
    return v[SUM_W-1:0];
  endfunction

  task automatic push_frame(int w, int o, int h, int t, int hd);
    frame_t f;
    f.water_sum  = clip_sum(w);
    f.oil_sum    = clip_sum(o);
    f.handle_sum = clip_sum(h);
    f.travel_sum = clip_sum(t);
    f.head_sum   = clip_sum(hd);
    frame_q.push_back(f);
  endtask

  task automatic load_random(int n);
    frame_t f;
    int     thr, avg;
    repeat (n) begin
      f.oil_sum    = rand_sum();
      f.handle_sum = rand_sum();
      f.travel_sum = rand_sum();
      f.head_sum   = rand_sum();
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          // water average close to one of the threshold registers
          case ($urandom_range(0, 2))
            0:       thr = cfg_shadow.water_zero_floor;
            1:       thr = cfg_shadow.break_threshold;
            default: thr = cfg_shadow.short_threshold;
          endcase
          f.water_sum = clip_sum(5 * (thr - 55) + int'($urandom_range(0, 14)) - 7);
        end
        3, 4: begin
          // pressure close to a band or idle edge
          case ($urandom_range(0, 2))
            0:       thr = cfg_shadow.band_low_kpa;
            1:       thr = cfg_shadow.band_high_kpa;
            default: thr = cfg_shadow.idle_limit_kpa;
          endcase
          avg = (thr * 65536 + 16384000) / 27499 + int'($urandom_range(0, 2)) - 1;
          f.water_sum = clip_sum(5 * (avg - 55) + int'($urandom_range(0, 4)));
        end
        default: f.water_sum = rand_sum();
      endcase
      frame_q.push_back(f);
    end
  endtask

  task automatic reg_write(logic [CFG_INDEX_W-1:0] idx, int unsigned val);
    @(posedge clk);
    cfg_wen   <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val[CFG_DATA_W-1:0];
    // only the low register bits are kept
    case (idx)
      REG_OIL_TEMP_LIMIT:   cfg_shadow.oil_temp_limit   = val[7:0];
      REG_WATER_ZERO_FLOOR: cfg_shadow.water_zero_floor = val[12:0];
      REG_BREAK_THRESHOLD:  cfg_shadow.break_threshold  = val[12:0];
      REG_SHORT_THRESHOLD:  cfg_shadow.short_threshold  = val[12:0];
      REG_BAND_LOW_KPA:     cfg_shadow.band_low_kpa     = val[10:0];
      REG_BAND_HIGH_KPA:    cfg_shadow.band_high_kpa    = val[10:0];
      REG_IDLE_LIMIT_KPA:   cfg_shadow.idle_limit_kpa   = val[10:0];
      default: ;
    endcase
  endtask

  task automatic program_regs(int unsigned lim, int unsigned flr, int unsigned brk,
                              int unsigned sht, int unsigned blo, int unsigned bhi,
                              int unsigned idl);
    reg_write(REG_OIL_TEMP_LIMIT, lim);
    reg_write(REG_WATER_ZERO_FLOOR, flr);
    reg_write(REG_BREAK_THRESHOLD, brk);
    reg_write(REG_SHORT_THRESHOLD, sht);
    reg_write(REG_BAND_LOW_KPA, blo);
    reg_write(REG_BAND_HIGH_KPA, bhi);
    reg_write(REG_IDLE_LIMIT_KPA, idl);
    reg_write(REG_UNUSED, $urandom_range(0, 8191));  // must be ignored
    @(posedge clk);
    cfg_wen <= 1'b0;
  endtask

  task automatic random_config();
    program_regs($urandom_range(0, 255), $urandom_range(0, 4150), $urandom_range(0, 4150),
                 $urandom_range(0, 4150), $urandom_range(0, 1500), $urandom_range(0, 1500),
                 $urandom_range(0, 1500));
  endtask

  task automatic drain();
    do @(posedge clk);
    while (frame_q.size() != 0 || s_tvalid || scaled_q.size() != 0);
  endtask

  task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  // ---------------- input driver ----------------

  always @(posedge clk) begin
    bit held;
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata  <= '0;
    end else begin
      held = s_tvalid;
      if (s_tvalid && s_tready) begin
        scaled_q.push_back(scale_frame(cur_frame, cfg_shadow));
        held = 1'b0;
      end
      if (!held) begin
        if (src_gap > 0) begin
          src_gap--;
        end else if (idle_on && $urandom_range(0, 99) < 15) begin
          src_gap = $urandom_range(0, 15);
        end else if (frame_q.size() != 0) begin
          cur_frame = frame_q.pop_front();
          held = 1'b1;
        end
      end
      s_tvalid <= held;
      s_tdata  <= {{(TDATA_IN_W - $bits(frame_t)){1'b0}}, cur_frame};
    end
  end

  // ---------------- result sink ready ----------------

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (stall_arm && !stall_done) begin
      stall_done = 1'b1;
      hold_left = LONG_HOLD;
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else if (sink_gap > 0) begin
      sink_gap--;
      m_tready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 99) < 12) begin
      sink_gap = $urandom_range(0, 15);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // ---------------- result monitor ----------------

  always @(posedge clk) begin
    result_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = result_t'(m_tdata[OUT_W-1:0]);
      if (scaled_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: result %h arrived with nothing expected", $time, got);
      end else begin
        want = scaled_q.pop_front();
        check_field("water_kpa", want.water_kpa, got.water_kpa);
        check_field("water_broken", want.water_broken, got.water_broken);
        check_field("water_shorted", want.water_shorted, got.water_shorted);
        check_field("water_alarm", want.water_alarm, got.water_alarm);
        check_field("oil_celsius", want.oil_celsius, got.oil_celsius);
        check_field("oil_alarm", want.oil_alarm, got.oil_alarm);
        check_field("handle_value", want.handle_value, got.handle_value);
        check_field("travel_value", want.travel_value, got.travel_value);
        check_field("head_value", want.head_value, got.head_value);
      end
    end
  end

  // ---------------- run sequence ----------------

  initial begin
    cfg_shadow = '{oil_temp_limit: 8'd80, water_zero_floor: 13'd640,
                   break_threshold: 13'd300, short_threshold: 13'd3050,
                   band_low_kpa: 11'd50, band_high_kpa: 11'd300, idle_limit_kpa: 11'd30};
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // corners under the reset register values
    push_frame(0, 0, 0, 0, 0);
    push_frame(SUM_TOP, SUM_TOP, SUM_TOP, SUM_TOP, SUM_TOP);  // overflow on all, oil open
    push_frame(SUM_RANGE, SUM_RANGE, SUM_RANGE, SUM_RANGE, SUM_RANGE);
    push_frame(2925, 0, 1, 4, 5);          // average right at the zero floor
    push_frame(2930, 14336, 31770, 31775, 31780);  // just above floor, oil at open edge
    push_frame(1220, 14337, 21845, 10922, 16384);  // broken, oil just open
    push_frame(1225, 4080, 10922, 21845, 8191);
    push_frame(14975, 4100, 0, 0, 0);      // average at short threshold
    push_frame(14980, 6120, 100, 200, 300);  // shorted
    push_frame(3060, 6140, 21845, 21845, 21845);   // around the idle limit
    push_frame(3300, 8680, 10922, 10922, 10922);   // around the band low edge
    push_frame(3305, 8700, 500, 600, 700);
    push_frame(6280, 13000, 20000, 15000, 10000);  // around the band high edge
    push_frame(6285, 13200, 1000, 2000, 3000);     // last oil segment clamped at zero
    push_frame(21845, 21845, 32766, 16383, 1);
    push_frame(10922, 10922, 2, 32767, 16385);
    push_frame(SUM_TOP, 0, 0, SUM_TOP, 0);
    push_frame(0, SUM_TOP, SUM_TOP, 0, SUM_TOP);
    load_random(60);
    drain();

    program_regs(0, 0, 0, 0, 0, 0, 0);     // negative pressure clamps to zero here
    load_random(90);
    drain();

    program_regs(255, 4150, 4150, 4150, 1500, 1500, 1500);
    load_random(90);
    drain();

    // writes wider than the registers keep only the low bits
    program_regs(8191, 8191, 8191, 8191, 8191, 8191, 8191);
    load_random(90);
    drain();

    // sender keeps offering against a long sink hold so the pipe backs up
    random_config();
    idle_on = 1'b0;
    stall_arm = 1'b1;
    load_random(150);
    drain();
    idle_on = 1'b1;

    repeat (2) begin
      random_config();
      load_random(90);
      drain();
    end

    // closing stretch at full rate
    idle_on = 1'b0;
    random_config();
    load_random(90);
    drain();

    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatches == 0 && scaled_q.size() == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

  initial begin
    #3_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

[filelist.f]
design/sfsa_pkg.sv
design/sfsa_front.sv
design/sfsa_div.sv
design/sfsa_temp.sv
design/sensor_frame_scaler_alarm.sv
dv/testbench.sv
